/* src/csm_pkg.sv */
package csm_pkg;

    // window depth and channel layout
    localparam int WINDOW     = 15;
    localparam int CORNERS    = 4;
    localparam int CHANNELS   = 2 * CORNERS;
    localparam int COORD_W    = 16;
    localparam int COUNT_IN_W = 3;

    // rank counters hold 0..WINDOW, step counter 0..WINDOW-1
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int STEP_W = $clog2(WINDOW);

    // sorted positions of the two middle entries (equal for odd WINDOW)
    localparam int RANK_LO = (WINDOW - 1) / 2;
    localparam int RANK_HI = WINDOW / 2;

    localparam int IN_TDATA_W  = ((COUNT_IN_W + CHANNELS * COORD_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((CHANNELS * COORD_W + 7) / 8) * 8;

    typedef logic [CHANNELS-1:0][COORD_W-1:0] chan_vec_t;
    typedef logic [CHANNELS-1:0][CNT_W-1:0]   chan_cnt_t;

    typedef struct packed {
        logic load;   // shift in a new beat, restart ranking
        logic count;  // one rank compare step, probes move on
    } cell_ctrl_t;

    typedef struct packed {
        logic [CHANNELS-1:0] lo;  // entry sits at sorted position RANK_LO
        logic [CHANNELS-1:0] hi;  // entry sits at sorted position RANK_HI
    } cell_match_t;

endpackage

/* src/csm_cell.sv */
module csm_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  csm_pkg::cell_ctrl_t   ctrl,
    input  logic [csm_pkg::CHANNELS-1:0] wr_mask,
    input  csm_pkg::chan_vec_t    wr_data,
    input  csm_pkg::chan_vec_t    prev_value,
    input  csm_pkg::chan_vec_t    prev_probe,
    output csm_pkg::chan_vec_t    value,
    output csm_pkg::chan_vec_t    probe,
    output csm_pkg::cell_match_t  match
);

    csm_pkg::chan_vec_t value_reg, value_next;
    csm_pkg::chan_vec_t probe_reg, probe_next;
    csm_pkg::chan_cnt_t lt_reg, lt_next;
    csm_pkg::chan_cnt_t le_reg, le_next;

    always_comb begin
        value_next = value_reg;
        probe_next = probe_reg;
        lt_next    = lt_reg;
        le_next    = le_reg;
        for (int c = 0; c < csm_pkg::CHANNELS; c++) begin
            if (ctrl.load) begin
                value_next[c] = wr_mask[c] ? wr_data[c] : prev_value[c];
                probe_next[c] = value_next[c];
                lt_next[c]    = '0;
                le_next[c]    = '0;
            end else if (ctrl.count) begin
                lt_next[c]    = lt_reg[c]
                              + csm_pkg::CNT_W'(probe_reg[c] < value_reg[c]);
                le_next[c]    = le_reg[c]
                              + csm_pkg::CNT_W'(probe_reg[c] <= value_reg[c]);
                probe_next[c] = prev_probe[c];
            end
        end
    end

    // entry is the k-th smallest iff lt <= k < le
    always_comb begin
        for (int c = 0; c < csm_pkg::CHANNELS; c++) begin
            match.lo[c] = (lt_reg[c] <= csm_pkg::CNT_W'(csm_pkg::RANK_LO))
                       && (csm_pkg::CNT_W'(csm_pkg::RANK_LO) < le_reg[c]);
            match.hi[c] = (lt_reg[c] <= csm_pkg::CNT_W'(csm_pkg::RANK_HI))
                       && (csm_pkg::CNT_W'(csm_pkg::RANK_HI) < le_reg[c]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= '0;
        end else begin
            value_reg <= value_next;
        end
    end

    always_ff @(posedge aclk) begin
        probe_reg <= probe_next;
        lt_reg    <= lt_next;
        le_reg    <= le_next;
    end

    assign value = value_reg;
    assign probe = probe_reg;

endmodule

/* src/corner_sliding_median.sv */
// Temporal median of a quadrilateral's four corners over the last WINDOW (15)
// beats, per coordinate channel. Each input beat carries a corner count
// (clamped to 4) and four x/y pairs; the first count corners are written into
// the window, the others keep the value they held WINDOW beats ago. Every input
// beat yields exactly one output beat with the eight channel medians (for an
// even WINDOW, the floor of the mean of the two middle values). A beat is
// shifted into the ring, WINDOW rank count steps run while a probe copy of
// every entry travels once around the ring of cells, then the medians are
// picked and registered. A new beat is taken only in the idle state, but the
// output register lets the next item start while the last result still
// waits. The window reads as all zero right after reset.
module corner_sliding_median (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [2:0] corner_count, then 16 bits each: corner0_x, corner0_y, corner1_x,
    // corner1_y, corner2_x, corner2_y, corner3_x, corner3_y; zero pad on top
    input  logic [csm_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // 16 bits each from bit 0: median0_x, median0_y, median1_x, median1_y,
    // median2_x, median2_y, median3_x, median3_y
    output logic [csm_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_COUNT  = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [csm_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [csm_pkg::OUT_TDATA_W-1:0] m_tdata_reg;
    logic                        out_load;
    logic                        accept;

    csm_pkg::cell_ctrl_t         ctrl;
    logic [csm_pkg::COUNT_IN_W-1:0] count_in, count_clamped;
    logic [csm_pkg::CHANNELS-1:0]   wr_mask;
    csm_pkg::chan_vec_t          wr_data;

    csm_pkg::chan_vec_t          cell_value [csm_pkg::WINDOW];
    csm_pkg::chan_vec_t          cell_probe [csm_pkg::WINDOW];
    csm_pkg::cell_match_t        cell_match [csm_pkg::WINDOW];

    csm_pkg::chan_vec_t          pick_lo, pick_hi, median;
    logic [csm_pkg::CHANNELS-1:0] any_lo, any_hi;
    logic [csm_pkg::COORD_W:0]   mid_sum;

    assign accept = s_tvalid && s_tready;

    // ---- input beat decode ----
    assign count_in      = s_tdata[csm_pkg::COUNT_IN_W-1:0];
    assign count_clamped = (count_in > csm_pkg::COUNT_IN_W'(csm_pkg::CORNERS))
                         ? csm_pkg::COUNT_IN_W'(csm_pkg::CORNERS) : count_in;

    always_comb begin
        for (int k = 0; k < csm_pkg::CORNERS; k++) begin
            wr_mask[2*k]   = csm_pkg::COUNT_IN_W'(k) < count_clamped;
            wr_mask[2*k+1] = csm_pkg::COUNT_IN_W'(k) < count_clamped;
        end
        for (int c = 0; c < csm_pkg::CHANNELS; c++) begin
            wr_data[c] = s_tdata[csm_pkg::COUNT_IN_W + c*csm_pkg::COORD_W +: csm_pkg::COORD_W];
        end
    end

    // ---- ring of window cells ----
    // On load the ring rotates by one: the head takes the new corner, or the
    // oldest entry from the tail when that corner is not valid. Entry order does
    // not matter to the median, so no write pointer is kept.
    for (genvar i = 0; i < csm_pkg::WINDOW; i++) begin : g_cell
        localparam int PREV = (i == 0) ? csm_pkg::WINDOW - 1 : i - 1;

        csm_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .wr_mask    ((i == 0) ? wr_mask : '0),
            .wr_data    (wr_data),
            .prev_value (cell_value[PREV]),
            .prev_probe (cell_probe[PREV]),
            .value      (cell_value[i]),
            .probe      (cell_probe[i]),
            .match      (cell_match[i])
        );
    end

    // ---- median pick ----
    // All cells matching a sorted position hold the same value, so OR works.
    always_comb begin
        pick_lo = '0;
        pick_hi = '0;
        any_lo  = '0;
        any_hi  = '0;
        for (int i = 0; i < csm_pkg::WINDOW; i++) begin
            for (int c = 0; c < csm_pkg::CHANNELS; c++) begin
                if (cell_match[i].lo[c]) begin
                    pick_lo[c] = pick_lo[c] | cell_value[i][c];
                end
                if (cell_match[i].hi[c]) begin
                    pick_hi[c] = pick_hi[c] | cell_value[i][c];
                end
            end
            any_lo = any_lo | cell_match[i].lo;
            any_hi = any_hi | cell_match[i].hi;
        end
    end

    // for odd WINDOW lo and hi coincide and the mean is the value itself
    always_comb begin
        mid_sum = '0;
        for (int c = 0; c < csm_pkg::CHANNELS; c++) begin
            mid_sum   = {1'b0, pick_lo[c]} + {1'b0, pick_hi[c]};
            median[c] = mid_sum[csm_pkg::COORD_W:1];
        end
    end

    // ---- sequencer ----
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        out_load   = 1'b0;
        ctrl.load  = accept;
        ctrl.count = (state_reg == ST_COUNT);
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT: begin
                if (step_reg == csm_pkg::STEP_W'(csm_pkg::WINDOW - 1)) begin
                    step_next  = '0;
                    state_next = ST_FINISH;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
                step_next  = '0;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= csm_pkg::OUT_TDATA_W'(median);
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // step counter only runs during ranking
    a_step_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_COUNT) |-> (step_reg == '0))
        else $error("step counter nonzero outside ranking");

    // an accepted beat starts ranking on the next cycle
    a_accept_count: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_COUNT))
        else $error("accepted beat did not start ranking");

    // completed ranks must place some entry at both middle positions
    a_rank_cover: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH) |-> ((&any_lo) && (&any_hi)))
        else $error("no entry found at a middle rank");

    // output beats only come out of the finish step
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("output raised outside finish");
`endif

endmodule
